// ----- src/wth_pkg.sv -----
// ============================================================================
// wth_pkg - windowed throughput histogram shared definitions
// Field widths, slice word codes, sequencer states and the bucket function.
// ============================================================================
package wth_pkg;

    localparam int TS_W        = 32;
    localparam int BYTES_W     = 48;
    localparam int WIN_W       = 16;
    localparam int WORD_W      = 32;
    localparam int IDX_W       = 4;
    localparam int CNT_W       = 16;
    localparam int SUM_W       = 48;
    localparam int NUM_W       = 58;
    localparam int DEN_W       = 32;
    localparam int NUM_BUCKETS = 12;
    localparam int BKT_W       = 4;
    localparam int DIV_STEPS   = NUM_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(1000);

    localparam logic [IDX_W-1:0] W_START = 4'd0;
    localparam logic [IDX_W-1:0] W_MIN   = 4'd1;
    localparam logic [IDX_W-1:0] W_MAX   = 4'd2;
    localparam logic [IDX_W-1:0] W_AVG   = 4'd3;
    localparam logic [IDX_W-1:0] W_LAST  = 4'd15;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_CHECK,
        ST_MUL1,
        ST_MUL2,
        ST_DIVGO,
        ST_RATE,
        ST_UPD1,
        ST_UPD2,
        ST_FLUSH,
        ST_AVG,
        ST_EMIT,
        ST_END
    } t_state;

    // log2 MB/s bucket of a KB/s rate
    function automatic logic [BKT_W-1:0] bucket_of(input logic [WORD_W-1:0] kbps);
        logic [BKT_W-1:0] b;
        b = '0;
        if (|kbps[WORD_W-1:20]) begin
            b = BKT_W'(NUM_BUCKETS - 1);
        end else begin
            for (int i = 0; i < 10; i++) begin
                if (kbps[10+i]) begin
                    b = BKT_W'(i + 1);
                end
            end
        end
        return b;
    endfunction

endpackage

// ----- src/wth_if.sv -----
// ============================================================================
// wth_if - windowed throughput histogram channels
// Sample, slice word and configuration write channels with valid/ready.
// ============================================================================
interface wth_in_if import wth_pkg::*;;
    logic               valid;
    logic               ready;
    logic [TS_W-1:0]    timestamp_ms;
    logic [BYTES_W-1:0] bytes_done;
    logic               last_sample;

    modport source(output valid, output timestamp_ms, output bytes_done,
                   output last_sample, input ready);
    modport sink(input valid, input timestamp_ms, input bytes_done,
                 input last_sample, output ready);
endinterface

interface wth_out_if import wth_pkg::*;;
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  word_index;
    logic [WORD_W-1:0] word_value;
    logic              last_word;

    modport source(output valid, output word_index, output word_value,
                   output last_word, input ready);
    modport sink(input valid, input word_index, input word_value,
                 input last_word, output ready);
endinterface

interface wth_cfg_if import wth_pkg::*;;
    logic             valid;
    logic             ready;
    logic [WIN_W-1:0] window_ms;

    modport source(output valid, output window_ms, input ready);
    modport sink(input valid, input window_ms, output ready);
endinterface

// ----- src/wth_div.sv -----
// ============================================================================
// wth_div - serial restoring divider
// One quotient bit per cycle; quotient valid when o_done pulses.
// ============================================================================
module wth_div import wth_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0]     r_rem;
    logic [DEN_W-1:0]     r_den;
    logic [NUM_W-1:0]     r_q;

    logic [DEN_W:0] rem_sh;
    logic [DEN_W:0] rem_sub;
    logic           ge;

    assign rem_sh  = {r_rem, r_q[NUM_W-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_W-2:0], ge};
            r_rem <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ----- src/windowed_throughput_histogram_top.sv -----
// ============================================================================
// windowed_throughput_histogram_top - windowed throughput histogram
// Groups progress samples into time windows and sends one 16-word slice
// (start, min, max, average, 12 log2 buckets) per window with rates.
// ============================================================================
//  channel  dir  handshake           payload
//  i_in     in   valid / ready       timestamp_ms, bytes_done, last_sample
//  o_out    out  valid / ready       word_index, word_value, last_word
//  i_cfg    in   valid / ready (=1)  window_ms
//
//  one sample at a time; ready only in idle between samples
//  sample with a rate: passes through the 58-step serial divider before the
//  next sample is taken; a sample without a rate skips the divider
//  closing a window adds the average divide plus the 16 output words,
//  which take longer when the sink stalls
//  synchronous active-low reset; window_ms returns to 1000
// ============================================================================
module windowed_throughput_histogram_top import wth_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wth_in_if.sink     i_in,
    wth_out_if.source  o_out,
    wth_cfg_if.sink    i_cfg
);

    t_state r_state;
    t_state n_state;

    logic [WIN_W-1:0]   r_window_ms;
    logic [TS_W-1:0]    r_t;
    logic [BYTES_W-1:0] r_b;
    logic               r_last;
    logic               r_close;
    logic               r_have_prev;
    logic [TS_W-1:0]    r_win_start;
    logic [TS_W-1:0]    r_prev_t;
    logic [BYTES_W-1:0] r_prev_b;
    logic [TS_W-1:0]    r_span;
    logic [TS_W-1:0]    r_dms;
    logic               r_bt;
    logic [BYTES_W-1:0] r_dbytes;
    logic               r_bb;
    logic [NUM_W-1:0]   r_num;
    logic [WORD_W-1:0]  r_kbps;
    logic [WORD_W-1:0]  r_min;
    logic [WORD_W-1:0]  r_max;
    logic [SUM_W-1:0]   r_sum;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_bucket [NUM_BUCKETS];
    logic [WORD_W-1:0]  r_avg;
    logic [IDX_W-1:0]   r_widx;

    logic               r_out_valid;
    logic [IDX_W-1:0]   r_word_index;
    logic [WORD_W-1:0]  r_word_value;
    logic               r_last_word;

    logic               close_now;
    logic               pair_now;
    logic               emit_now;
    logic               in_ready;
    logic               div_start;
    logic               emit_load;
    logic [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    logic               div_done;
    logic [NUM_W-1:0]   div_quot;
    logic [BKT_W-1:0]   bkt;
    logic [SUM_W:0]     sum_ext;
    logic [WORD_W-1:0]  word_mux;
    logic [TS_W:0]      dms_ext;
    logic [BYTES_W:0]   db_ext;

    wth_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign close_now = r_have_prev && (r_span >= {16'b0, r_window_ms});
    assign pair_now  = r_have_prev && !close_now && !r_bt && (r_dms != '0)
                       && !r_bb && (r_dbytes != '0);
    assign emit_now  = (r_close || r_last) && (r_count != '0);

    assign dms_ext = {1'b0, r_t} - {1'b0, r_prev_t};
    assign db_ext  = {1'b0, r_b} - {1'b0, r_prev_b};
    assign bkt     = bucket_of(r_kbps);
    assign sum_ext = {1'b0, r_sum} + {17'b0, r_kbps};

    assign div_num = (r_state == ST_FLUSH) ? {10'b0, r_sum} : r_num;
    assign div_den = (r_state == ST_FLUSH) ? {16'b0, r_count} : r_dms;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_in.valid) n_state = ST_DIFF;
            ST_DIFF:  n_state = ST_CHECK;
            ST_CHECK: n_state = pair_now ? ST_MUL1 : ST_FLUSH;
            ST_MUL1:  n_state = ST_MUL2;
            ST_MUL2:  n_state = ST_DIVGO;
            ST_DIVGO: n_state = ST_RATE;
            ST_RATE:  if (div_done) n_state = ST_UPD1;
            ST_UPD1:  n_state = ST_UPD2;
            ST_UPD2:  n_state = ST_FLUSH;
            ST_FLUSH: n_state = emit_now ? ST_AVG : ST_END;
            ST_AVG:   if (div_done) n_state = ST_EMIT;
            ST_EMIT:  if (emit_load && r_widx == W_LAST) n_state = ST_END;
            ST_END:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        in_ready  = (r_state == ST_IDLE);
        div_start = (r_state == ST_DIVGO) || (r_state == ST_FLUSH && emit_now);
        emit_load = (r_state == ST_EMIT) && (!r_out_valid || o_out.ready);
    end

    always_comb begin
        unique case (r_widx)
            W_START: word_mux = r_win_start;
            W_MIN:   word_mux = (r_min == '1) ? '0 : r_min;
            W_MAX:   word_mux = r_max;
            W_AVG:   word_mux = r_avg;
            default: word_mux = {16'b0, r_bucket[0]};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_window_ms <= WIN_RESET;
            r_have_prev <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_window_ms <= i_cfg.window_ms;
            end
            if (r_state == ST_END) begin
                r_have_prev <= !r_last;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_word_index <= r_widx;
            r_word_value <= word_mux;
            r_last_word  <= (r_widx == W_LAST);
        end
    end

    // window statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min   <= '1;
            r_max   <= '0;
            r_sum   <= '0;
            r_count <= '0;
            for (int i = 0; i < NUM_BUCKETS; i++) begin
                r_bucket[i] <= '0;
            end
        end else begin
            case (r_state)
                ST_UPD1: begin
                    if (r_bucket[bkt] != '1) begin
                        r_bucket[bkt] <= r_bucket[bkt] + 1'b1;
                    end
                    if (r_kbps < r_min) begin
                        r_min <= r_kbps;
                    end
                    if (r_kbps > r_max) begin
                        r_max <= r_kbps;
                    end
                end
                ST_UPD2: begin
                    r_sum <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
                    if (r_count != '1) begin
                        r_count <= r_count + 1'b1;
                    end
                end
                ST_EMIT: begin
                    // buckets drain through entry 0
                    if (emit_load && r_widx > W_AVG) begin
                        for (int i = 0; i < NUM_BUCKETS - 1; i++) begin
                            r_bucket[i] <= r_bucket[i+1];
                        end
                        r_bucket[NUM_BUCKETS-1] <= '0;
                    end
                end
                ST_END: begin
                    if (r_close || r_last) begin
                        r_min   <= '1;
                        r_max   <= '0;
                        r_sum   <= '0;
                        r_count <= '0;
                        for (int i = 0; i < NUM_BUCKETS; i++) begin
                            r_bucket[i] <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // sample datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_t    <= i_in.timestamp_ms;
                r_b    <= i_in.bytes_done;
                r_last <= i_in.last_sample;
            end
            ST_DIFF: begin
                r_span   <= r_t - r_win_start;
                r_dms    <= dms_ext[TS_W-1:0];
                r_bt     <= dms_ext[TS_W];
                r_dbytes <= db_ext[BYTES_W-1:0];
                r_bb     <= db_ext[BYTES_W];
            end
            ST_CHECK: r_close <= close_now;
            ST_MUL1:  r_num <= {r_dbytes, 10'b0} - {6'b0, r_dbytes, 4'b0};
            ST_MUL2:  r_num <= r_num - {7'b0, r_dbytes, 3'b0};
            ST_RATE: begin
                if (div_done) begin
                    r_kbps <= div_quot[41:10];
                end
            end
            ST_FLUSH: r_widx <= W_START;
            ST_AVG: begin
                if (div_done) begin
                    r_avg <= (div_quot[NUM_W-1:WORD_W] != '0) ? '1
                                                              : div_quot[WORD_W-1:0];
                end
            end
            ST_EMIT: begin
                if (emit_load) begin
                    r_widx <= r_widx + 1'b1;
                end
            end
            ST_END: begin
                if (r_last) begin
                    r_win_start <= '0;
                    r_prev_t    <= '0;
                    r_prev_b    <= '0;
                end else begin
                    if (!r_have_prev || r_close) begin
                        r_win_start <= r_t;
                    end
                    r_prev_t <= r_t;
                    r_prev_b <= r_b;
                end
            end
            default: ;
        endcase
    end

    assign i_in.ready       = in_ready;
    assign i_cfg.ready      = 1'b1;
    assign o_out.valid      = r_out_valid;
    assign o_out.word_index = r_word_index;
    assign o_out.word_value = r_word_value;
    assign o_out.last_word  = r_last_word;

endmodule
